[rtl/core/lpft_pkg.sv]
// lpft_pkg: shared types and constants for the lru page frame table
// no dependencies; used by lpft_cell and lru_page_frame_table
package lpft_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_W     = 20;
  localparam int RANK_W     = $clog2(MAX_FRAMES);
  localparam int CNT_W      = RANK_W + 1;
  localparam int FAULT_W    = 32;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } lpft_state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              clr;
    logic              upd;
    logic              hit;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  limit;
    logic [RANK_W-1:0] last_rank;
  } lpft_ctrl_t;

  // per-cell status back to the controller
  typedef struct packed {
    logic              match;
    logic              pick;
    logic              lru;
    logic [RANK_W-1:0] rank;
  } lpft_stat_t;

endpackage

[rtl/core/lru_page_frame_table.sv]
// lru_page_frame_table: fully associative page frame table, lru replacement
// depends on lpft_pkg and lpft_cell (a row of MAX_FRAMES frame cells)
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | in_page_id                              | start & !busy
//  result  | out_hit, out_frame_index,               | out_valid, one cycle,
//          | out_fault_count, out_disabled           | no back-pressure
//  config  | cfg_wdata                               | cfg_we
//
// a beat: the accept edge latches the page and enters the update state, where it
// is compared against all cells; the row update and the result are registered.
// busy is high for that one update cycle, so no new beat is taken until it ends.
// rst_n is synchronous active low: all frames empty, frames_in_use = 16,
// fault count zero. a cfg write clears the row and the fault count.
// the receiver cannot stall: out_valid is a single-cycle strobe.
module lru_page_frame_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lpft_pkg::PAGE_W-1:0]   in_page_id,
  input  logic                          cfg_we,
  input  logic [lpft_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [lpft_pkg::RANK_W-1:0]   out_frame_index,
  output logic [lpft_pkg::FAULT_W-1:0]  out_fault_count,
  output logic                          out_disabled
);

  localparam int N = lpft_pkg::MAX_FRAMES;

  lpft_pkg::lpft_state_t             state_r, state_nxt;
  logic [lpft_pkg::PAGE_W-1:0]       page_r;
  logic [lpft_pkg::CNT_W-1:0]        frames_r;
  logic [lpft_pkg::FAULT_W-1:0]      fault_r, fault_nxt;

  logic                              out_valid_r, out_hit_r, out_disabled_r;
  logic [lpft_pkg::RANK_W-1:0]       out_idx_r, out_idx_nxt;

  logic                              accept, upd_state, upd_en;
  logic [lpft_pkg::CNT_W-1:0]        n_act;
  logic                              tbl_off;

  lpft_pkg::lpft_ctrl_t              ctrl;
  lpft_pkg::lpft_stat_t              stat [N];
  logic [N-1:0]                      active, tgt, match_v, pick_v, lru_v;
  logic [N:0]                        empty_chain;
  logic                              any_match, any_empty;
  logic [lpft_pkg::RANK_W-1:0]       hit_rank;

  // ---------------------------------------------------------------- control
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpft_pkg::ST_IDLE: begin
        if (accept) state_nxt = lpft_pkg::ST_UPD;
      end
      lpft_pkg::ST_UPD: begin
        state_nxt = lpft_pkg::ST_IDLE;
      end
      default: state_nxt = lpft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    upd_state = 1'b0;
    unique case (state_r)
      lpft_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      lpft_pkg::ST_UPD: begin
        busy      = 1'b1;
        upd_state = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) page_r <= in_page_id;
  end

  // register values above the frame count behave as the full row
  assign n_act   = (frames_r > lpft_pkg::CNT_W'(N)) ? lpft_pkg::CNT_W'(N) : frames_r;
  assign tbl_off = (n_act == '0);
  assign upd_en  = upd_state && !tbl_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= lpft_pkg::CNT_W'(N);
    end else if (cfg_we) begin
      frames_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- cell row
  always_comb begin
    for (int i = 0; i < N; i++) begin
      active[i]  = (lpft_pkg::CNT_W'(i) < n_act);
      match_v[i] = stat[i].match;
      pick_v[i]  = stat[i].pick;
      lru_v[i]   = stat[i].lru;
    end
  end

  assign any_match = |match_v;
  assign any_empty = empty_chain[0];

  // rank of the hit frame sets how far the others age
  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < N; i++) begin
      if (match_v[i]) hit_rank = hit_rank | stat[i].rank;
    end
  end

  // target frame: the hit, else the highest empty slot, else the oldest rank
  always_comb begin
    if (any_match)      tgt = match_v;
    else if (any_empty) tgt = pick_v;
    else                tgt = lru_v;
  end

  always_comb begin
    ctrl.clr       = cfg_we;
    ctrl.upd       = upd_en;
    ctrl.hit       = any_match;
    ctrl.page      = page_r;
    ctrl.limit     = any_match ? {1'b0, hit_rank} : lpft_pkg::CNT_W'(N);
    ctrl.last_rank = lpft_pkg::RANK_W'(n_act - 1'b1);
  end

  assign empty_chain[N] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lpft_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .active    (active[g]),
      .tgt       (tgt[g]),
      .empty_in  (empty_chain[g+1]),
      .empty_out (empty_chain[g]),
      .stat      (stat[g])
    );
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    out_idx_nxt = '0;
    for (int i = 0; i < N; i++) begin
      if (tgt[i]) out_idx_nxt = out_idx_nxt | lpft_pkg::RANK_W'(i);
    end
  end

  // fault count saturates at all ones
  always_comb begin
    fault_nxt = fault_r;
    if (upd_en && !any_match && (fault_r != '1)) fault_nxt = fault_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      fault_r <= '0;
    end else begin
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= upd_state;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_state) begin
      out_hit_r      <= !tbl_off && any_match;
      out_idx_r      <= tbl_off ? '0 : out_idx_nxt;
      out_disabled_r <= tbl_off;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_frame_index = out_idx_r;
  assign out_fault_count = fault_r;
  assign out_disabled    = out_disabled_r;

  // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
  a_res_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(upd_state))
    else $error("result strobe without an update cycle");

  a_tgt_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en |-> $onehot(tgt))
    else $error("update must hit exactly one frame");

  a_hit_not_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_disabled)
    else $error("hit reported on a disabled table");

  a_one_upd: assert property (@(posedge clk) disable iff (!rst_n)
    upd_state |=> !upd_state)
    else $error("update cycle lasted more than one clock");
`endif

endmodule

[rtl/core/lpft_cell.sv]
// lpft_cell: one page frame with valid bit, page tag and recency rank
// depends on lpft_pkg; chained through the empty-frame ripple
module lpft_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lpft_pkg::lpft_ctrl_t ctrl,
  input  logic                active,
  input  logic                tgt,
  input  logic                empty_in,
  output logic                empty_out,
  output lpft_pkg::lpft_stat_t stat
);

  logic                           valid_r, valid_nxt;
  logic [lpft_pkg::PAGE_W-1:0]    page_r, page_nxt;
  logic [lpft_pkg::RANK_W-1:0]    rank_r, rank_nxt;
  logic                           empty_here;

  assign empty_here = active && !valid_r;
  // higher-numbered empty frames win, so the ripple runs from the top down
  assign empty_out  = empty_in || empty_here;

  always_comb begin
    stat.match = valid_r && (page_r == ctrl.page);
    stat.pick  = empty_here && !empty_in;
    stat.lru   = valid_r && (rank_r == ctrl.last_rank);
    stat.rank  = rank_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    rank_nxt  = rank_r;
    if (ctrl.upd) begin
      if (tgt) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
        if (!ctrl.hit) begin
          page_nxt = ctrl.page;
        end
      end else if (valid_r && ({1'b0, rank_r} < ctrl.limit)) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule
